// ===== hdl/assert_macros.svh =====
// assertion helpers, compiled away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// property checked on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hdl/tcce_pkg.sv =====
package tcce_pkg;

    // geometry limits
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 128;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);

    // register indexes
    localparam logic [1:0] CFG_COLUMNS   = 2'd0;
    localparam logic [1:0] CFG_ROWS      = 2'd1;
    localparam logic [1:0] CFG_TEXT_MODE = 2'd2;

    // operations
    localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
    localparam logic [2:0] OP_SET_CURSOR = 3'd1;
    localparam logic [2:0] OP_CLEAR      = 3'd2;
    localparam logic [2:0] OP_SET_ATTR   = 3'd3;
    localparam logic [2:0] OP_MARK       = 3'd4;

    // commands
    localparam logic [2:0] CMD_DRAW        = 3'd0;
    localparam logic [2:0] CMD_SCROLL      = 3'd1;
    localparam logic [2:0] CMD_FILL_REGION = 3'd2;
    localparam logic [2:0] CMD_FILL_ALL    = 3'd3;
    localparam logic [2:0] CMD_NONE        = 3'd4;

    // status codes
    localparam logic ST_OK          = 1'b0;
    localparam logic ST_UNSUPPORTED = 1'b1;

    // control characters
    localparam logic [15:0] CH_BS    = 16'h0008;
    localparam logic [15:0] CH_TAB   = 16'h0009;
    localparam logic [15:0] CH_LF    = 16'h000A;
    localparam logic [15:0] CH_CR    = 16'h000D;
    localparam logic [15:0] CH_SPACE = 16'h0020;

    // reset values
    localparam logic [COL_W-1:0] RST_COL_LAST = COL_W'(79);
    localparam logic [ROW_W-1:0] RST_ROW_LAST = ROW_W'(24);
    localparam logic [6:0]       RST_ATTR     = 7'd7;
    localparam logic [23:0]      RST_FG       = 24'hbfbfbf;
    localparam logic [23:0]      RST_BG       = 24'h000000;

    // output queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h000098, 24'h009800, 24'h009898,
        24'h980000, 24'h980098, 24'h989800, 24'hbfbfbf,
        24'h303030, 24'h0000ff, 24'h00ff00, 24'h00ffff,
        24'hff0000, 24'hff00ff, 24'hffff00, 24'hffffff
    };

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] char_code;
        logic [15:0] target_column;
        logic [15:0] target_row;
        logic [7:0]  attribute;
    } t_item;

    typedef struct packed {
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
        logic             text_mode;
    } t_geom;

    typedef struct packed {
        logic [COL_W-1:0] cur_col;
        logic [ROW_W-1:0] cur_row;
        logic [COL_W-1:0] max_col;
        logic [ROW_W-1:0] max_row;
        logic [6:0]       attr;
        logic [23:0]      fg;
        logic [23:0]      bg;
        logic             uncontrolled;
    } t_state;

    typedef struct packed {
        logic [2:0]       command;
        logic [15:0]      glyph_code;
        logic [COL_W-1:0] cell_column;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W:0]   region_columns;
        logic [ROW_W:0]   region_rows;
        logic [23:0]      fg_rgb;
        logic [23:0]      bg_rgb;
        logic             status;
        logic             last;
    } t_result;

    typedef struct packed {
        logic has_room;
        logic not_empty;
    } t_q_stat;

endpackage

// ===== hdl/tcce_step.sv =====
module tcce_step
    import tcce_pkg::*;
(
    input  t_item   i_item,
    input  t_state  i_state,
    input  t_geom   i_geom,
    output t_state  o_state,
    output t_result o_res0,
    output t_result o_res1,
    output logic    o_two
);

    logic [23:0] new_bg;

    always_comb begin
        o_state = i_state;
        o_res0  = '0;
        o_res1  = '0;
        o_two   = 1'b0;
        new_bg  = PALETTE[{1'b0, i_item.attribute[6:4]}];

        o_res0.command = CMD_NONE;
        o_res0.status  = ST_OK;

        unique case (i_item.op)
            OP_PUT_CHAR: begin
                if (!i_geom.text_mode) begin
                    o_res0.status = ST_UNSUPPORTED;
                end else if (i_item.char_code == CH_CR) begin
                    o_state.cur_col = '0;
                end else if (i_item.char_code == CH_BS) begin
                    if (i_state.cur_col == '0 && i_state.cur_row != '0) begin
                        o_state.cur_row = i_state.cur_row - ROW_W'(1);
                        o_state.cur_col = i_geom.col_last;
                        o_res0.command  = CMD_DRAW;
                    end else if (i_state.cur_col != '0) begin
                        o_state.cur_col = i_state.cur_col - COL_W'(1);
                        o_res0.command  = CMD_DRAW;
                    end
                    if (o_res0.command == CMD_DRAW) begin
                        o_res0.glyph_code  = CH_SPACE;
                        o_res0.cell_column = o_state.cur_col;
                        o_res0.cell_row    = o_state.cur_row;
                    end
                end else if (i_item.char_code == CH_LF) begin
                    if (i_state.cur_row < i_geom.row_last) begin
                        o_state.cur_row = i_state.cur_row + ROW_W'(1);
                        if (o_state.cur_row > i_state.max_row) begin
                            o_state.max_row = o_state.cur_row;
                        end
                    end else begin
                        o_res0.command        = CMD_SCROLL;
                        o_res0.region_columns = {1'b0, i_state.max_col} + (COL_W+1)'(1);
                        o_res0.region_rows    = {1'b0, i_geom.row_last};
                    end
                end else begin
                    o_res0.command     = CMD_DRAW;
                    o_res0.glyph_code  = (i_item.char_code == CH_TAB) ? CH_SPACE
                                                                      : i_item.char_code;
                    o_res0.cell_column = i_state.cur_col;
                    o_res0.cell_row    = i_state.cur_row;
                    if (i_state.cur_col < i_geom.col_last) begin
                        o_state.cur_col = i_state.cur_col + COL_W'(1);
                        if (o_state.cur_col > i_state.max_col) begin
                            o_state.max_col = o_state.cur_col;
                        end
                    end else if (i_state.cur_row < i_geom.row_last) begin
                        o_state.cur_col = '0;
                        o_state.cur_row = i_state.cur_row + ROW_W'(1);
                        if (o_state.cur_row > i_state.max_row) begin
                            o_state.max_row = o_state.cur_row;
                        end
                    end else begin
                        // wrap on the bottom row: draw, then scroll
                        o_two                 = 1'b1;
                        o_state.cur_col       = '0;
                        o_res1.command        = CMD_SCROLL;
                        o_res1.status         = ST_OK;
                        o_res1.region_columns = {1'b0, i_state.max_col} + (COL_W+1)'(1);
                        o_res1.region_rows    = {1'b0, i_geom.row_last};
                    end
                end
            end
            OP_SET_CURSOR: begin
                o_state.cur_col = (i_item.target_column > 16'(i_geom.col_last))
                                ? i_geom.col_last : i_item.target_column[COL_W-1:0];
                o_state.cur_row = (i_item.target_row > 16'(i_geom.row_last))
                                ? i_geom.row_last : i_item.target_row[ROW_W-1:0];
                if (o_state.cur_col > i_state.max_col) begin
                    o_state.max_col = o_state.cur_col;
                end
                if (o_state.cur_row > i_state.max_row) begin
                    o_state.max_row = o_state.cur_row;
                end
            end
            OP_CLEAR: begin
                if (!i_geom.text_mode) begin
                    o_res0.status = ST_UNSUPPORTED;
                end else begin
                    if (i_state.uncontrolled) begin
                        o_res0.command       = CMD_FILL_ALL;
                        o_state.uncontrolled = 1'b0;
                    end else begin
                        o_res0.command        = CMD_FILL_REGION;
                        o_res0.region_columns = {1'b0, i_state.max_col} + (COL_W+1)'(1);
                        o_res0.region_rows    = {1'b0, i_state.max_row} + (ROW_W+1)'(1);
                    end
                    o_state.cur_col = '0;
                    o_state.cur_row = '0;
                    o_state.max_col = '0;
                    o_state.max_row = '0;
                end
            end
            OP_SET_ATTR: begin
                if (i_item.attribute[7]) begin
                    o_res0.status = ST_UNSUPPORTED;
                end else if (i_item.attribute[6:0] != i_state.attr) begin
                    if (new_bg != i_state.bg) begin
                        o_state.uncontrolled = 1'b1;
                    end
                    o_state.fg   = PALETTE[i_item.attribute[3:0]];
                    o_state.bg   = new_bg;
                    o_state.attr = i_item.attribute[6:0];
                end
            end
            OP_MARK: begin
                o_state.uncontrolled = 1'b1;
            end
            default: begin
                o_res0.status = ST_UNSUPPORTED;
            end
        endcase

        // colours after the operation ride on every result
        o_res0.fg_rgb = o_state.fg;
        o_res0.bg_rgb = o_state.bg;
        o_res1.fg_rgb = o_state.fg;
        o_res1.bg_rgb = o_state.bg;
        o_res0.last   = !o_two;
        o_res1.last   = 1'b1;
    end

endmodule

// ===== hdl/tcce_out_queue.sv =====
module tcce_out_queue
    import tcce_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  logic    i_push_two,
    input  t_result i_res0,
    input  t_result i_res1,
    input  logic    i_pop,
    output t_result o_head,
    output t_q_stat o_stat
);

    t_result              r_entry [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]     r_count, n_count;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [1:0]           push_n;

    assign wr_ptr_next = r_wr_ptr + Q_PTR_W'(1);
    assign push_n      = !i_push ? 2'd0 : (i_push_two ? 2'd2 : 2'd1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(push_n);
        n_rd_ptr = r_rd_ptr + Q_PTR_W'(i_pop);
        n_count  = r_count + (Q_PTR_W+1)'(push_n) - (Q_PTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_res0;
            if (i_push_two) begin
                r_entry[wr_ptr_next] <= i_res1;
            end
        end
    end

    assign o_head           = r_entry[r_rd_ptr];
    // room for a full two-result item
    assign o_stat.has_room  = r_count <= (Q_PTR_W+1)'(Q_DEPTH - 2);
    assign o_stat.not_empty = r_count != '0;

endmodule

// ===== hdl/text_console_cursor_engine_core.sv =====
// text console cursor engine
//
// input channel: one operation per request (op, char_code, target_column,
// target_row, attribute) under i_in_valid / o_in_stall. output channel: one
// command per request (draw, scroll, fill, none) with current colours under
// o_out_valid / i_out_stall; o_last marks the final command of an operation.
// an operation gives one command, a put char that wraps on the bottom row
// gives two (draw, then scroll), pushed into the output queue together.
// an accepted operation passes the input register and then the output queue.
// throughput: one operation per cycle while the output queue has room; the
// single-pass update of the cursor registers sets that rate, and a
// two-command operation takes two entries of the output queue.
// configuration: i_cfg_we writes columns, rows or text mode by index at once;
// write only while no operation is in flight.
// reset (synchronous, active low): cursor at the origin, attribute 7,
// light gray on black, 80 x 25, text mode, input register and queue empty.
// output stall: commands back up in a four-entry queue; once it cannot take
// a two-command operation the input register holds and o_in_stall rises.
`include "assert_macros.svh"

module text_console_cursor_engine_core
    import tcce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [8:0]        i_cfg_data,
    // operation requests
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_op,
    input  logic [15:0]       i_char_code,
    input  logic [15:0]       i_target_column,
    input  logic [15:0]       i_target_row,
    input  logic [7:0]        i_attribute,
    // command requests
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_command,
    output logic [15:0]       o_glyph_code,
    output logic [COL_W-1:0]  o_cell_column,
    output logic [ROW_W-1:0]  o_cell_row,
    output logic [COL_W:0]    o_region_columns,
    output logic [ROW_W:0]    o_region_rows,
    output logic [23:0]       o_fg_rgb,
    output logic [23:0]       o_bg_rgb,
    output logic              o_status,
    output logic              o_last
);

    // configuration, stored already clamped as last column / last row
    t_geom   r_geom, n_geom;
    logic [8:0] cols_m1;
    logic [7:0] rows_m1;

    // input register
    logic    r_in_valid;
    t_item   r_item;
    logic    in_accept;

    // console state
    t_state  r_state, step_state;
    t_result res0, res1;
    logic    two;

    // queue side
    t_result head;
    t_q_stat q_stat;
    logic    advance;
    logic    pop;

    // clamp columns to 1..MAX_COLUMNS and rows to 1..MAX_ROWS, minus one
    assign cols_m1 = i_cfg_data - 9'd1;
    assign rows_m1 = i_cfg_data[7:0] - 8'd1;

    always_comb begin
        n_geom = r_geom;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLUMNS: begin
                    if (i_cfg_data == '0) begin
                        n_geom.col_last = '0;
                    end else if (i_cfg_data > 9'(MAX_COLUMNS)) begin
                        n_geom.col_last = COL_W'(MAX_COLUMNS - 1);
                    end else begin
                        n_geom.col_last = cols_m1[COL_W-1:0];
                    end
                end
                CFG_ROWS: begin
                    if (i_cfg_data[7:0] == '0) begin
                        n_geom.row_last = '0;
                    end else if (i_cfg_data[7:0] > 8'(MAX_ROWS)) begin
                        n_geom.row_last = ROW_W'(MAX_ROWS - 1);
                    end else begin
                        n_geom.row_last = rows_m1[ROW_W-1:0];
                    end
                end
                CFG_TEXT_MODE: begin
                    n_geom.text_mode = i_cfg_data[0];
                end
                default: begin
                    // index beyond the register list is ignored
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.col_last  <= RST_COL_LAST;
            r_geom.row_last  <= RST_ROW_LAST;
            r_geom.text_mode <= 1'b1;
        end else begin
            r_geom <= n_geom;
        end
    end

    // input register moves on as soon as the queue can take two commands
    assign advance    = r_in_valid && q_stat.has_room;
    assign o_in_stall = r_in_valid && !q_stat.has_room;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.op            <= i_op;
            r_item.char_code     <= i_char_code;
            r_item.target_column <= i_target_column;
            r_item.target_row    <= i_target_row;
            r_item.attribute     <= i_attribute;
        end
    end

    // one pass of cursor / colour update per operation
    tcce_step u_step (
        .i_item  (r_item),
        .i_state (r_state),
        .i_geom  (r_geom),
        .o_state (step_state),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_two   (two)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur_col      <= '0;
            r_state.cur_row      <= '0;
            r_state.max_col      <= '0;
            r_state.max_row      <= '0;
            r_state.attr         <= RST_ATTR;
            r_state.fg           <= RST_FG;
            r_state.bg           <= RST_BG;
            r_state.uncontrolled <= 1'b0;
        end else if (advance) begin
            r_state <= step_state;
        end
    end

    // command queue in front of the output
    assign pop = o_out_valid && !i_out_stall;

    tcce_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (advance),
        .i_push_two (two),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (q_stat)
    );

    assign o_out_valid      = q_stat.not_empty;
    assign o_command        = head.command;
    assign o_glyph_code     = head.glyph_code;
    assign o_cell_column    = head.cell_column;
    assign o_cell_row       = head.cell_row;
    assign o_region_columns = head.region_columns;
    assign o_region_rows    = head.region_rows;
    assign o_fg_rgb         = head.fg_rgb;
    assign o_bg_rgb         = head.bg_rgb;
    assign o_status         = head.status;
    assign o_last           = head.last;

    // the input side only holds off while an operation is parked
    `ASSERT_CLK_ALWAYS(a_stall_needs_item, i_clk, o_in_stall |-> r_in_valid)

    // an operation that leaves the input register shows up on the output
    `ASSERT_CLK(a_advance_to_out, i_clk, i_rst_n, advance |=> o_out_valid)

    // the scroll after a wrap was queued with its draw, so it is always there
    `ASSERT_CLK(a_second_follows, i_clk, i_rst_n,
        (o_out_valid && !o_last) |=> o_out_valid)

    // a draw carries no region
    `ASSERT_CLK(a_draw_no_region, i_clk, i_rst_n,
        (o_out_valid && o_command == CMD_DRAW) |-> (o_region_columns == '0))

endmodule

// ===== dv/text_console_cursor_engine_core_tb.sv =====
module text_console_cursor_engine_core_tb;
    import tcce_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 4;
    // longest quiet stretch is the back-pressure hold plus a few sender gaps
    localparam int QUIET_LIMIT   = 4000;
    localparam int PRESSURE_HOLD = 300;
    localparam int PRESSURE_REQS = 40;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_REQS    = 100;
    localparam int MAX_REPORTS   = 100;

    // idling modes, cycled through the random phases
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_COLUMNS;
    logic [8:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  req_op = OP_PUT_CHAR;
    logic [15:0] req_char = '0;
    logic [15:0] req_col = '0;
    logic [15:0] req_row = '0;
    logic [7:0]  req_attr = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]         cmd_code;
    logic [15:0]        cmd_glyph;
    logic [COL_W-1:0]   cmd_col;
    logic [ROW_W-1:0]   cmd_row;
    logic [COL_W:0]     cmd_rcols;
    logic [ROW_W:0]     cmd_rrows;
    logic [23:0]        cmd_fg;
    logic [23:0]        cmd_bg;
    logic               cmd_status;
    logic               cmd_last;

    text_console_cursor_engine_core i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_op             (req_op),
        .i_char_code      (req_char),
        .i_target_column  (req_col),
        .i_target_row     (req_row),
        .i_attribute      (req_attr),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_command        (cmd_code),
        .o_glyph_code     (cmd_glyph),
        .o_cell_column    (cmd_col),
        .o_cell_row       (cmd_row),
        .o_region_columns (cmd_rcols),
        .o_region_rows    (cmd_rrows),
        .o_fg_rgb         (cmd_fg),
        .o_bg_rgb         (cmd_bg),
        .o_status         (cmd_status),
        .o_last           (cmd_last)
    );

    // console model state, mirrors the block after reset
    int unsigned reg_cols = 80;
    int unsigned reg_rows = 25;
    bit          text_on = 1'b1;
    int unsigned cur_col = 0;
    int unsigned cur_row = 0;
    int unsigned used_col = 0;
    int unsigned used_row = 0;
    logic [6:0]  attr_now = RST_ATTR;
    logic [23:0] fg_now = RST_FG;
    logic [23:0] bg_now = RST_BG;
    bit          uncontrolled = 1'b0;

    t_result expected_cmds[$];
    t_result op_cmds[$];

    int fail_count = 0;
    int quiet_cycles = 0;
    int reqs_sent = 0;
    int cmds_checked = 0;
    int draws_seen = 0;
    int scrolls_seen = 0;
    int fills_seen = 0;
    int held_cycles = 0;
    int geometry_count = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;

    initial begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // output side: random stall, or one long hold when asked
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (PRESSURE_HOLD - 1) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        case (idx)
            4'd0:  return 24'h000000;
            4'd1:  return 24'h000098;
            4'd2:  return 24'h009800;
            4'd3:  return 24'h009898;
            4'd4:  return 24'h980000;
            4'd5:  return 24'h980098;
            4'd6:  return 24'h989800;
            4'd7:  return 24'hbfbfbf;
            4'd8:  return 24'h303030;
            4'd9:  return 24'h0000ff;
            4'd10: return 24'h00ff00;
            4'd11: return 24'h00ffff;
            4'd12: return 24'hff0000;
            4'd13: return 24'hff00ff;
            4'd14: return 24'hffff00;
            default: return 24'hffffff;
        endcase
    endfunction

    // register values outside the legal range are clamped
    function automatic int unsigned live_cols();
        if (reg_cols < 1) return 1;
        if (reg_cols > MAX_COLUMNS) return MAX_COLUMNS;
        return reg_cols;
    endfunction

    function automatic int unsigned live_rows();
        if (reg_rows < 1) return 1;
        if (reg_rows > MAX_ROWS) return MAX_ROWS;
        return reg_rows;
    endfunction

    function automatic void add_cmd(input logic [2:0] command, input int unsigned glyph,
                                    input int unsigned col, input int unsigned row,
                                    input int unsigned rcols, input int unsigned rrows,
                                    input logic status);
        t_result r;
        r = '0;
        r.command        = command;
        r.glyph_code     = glyph[15:0];
        r.cell_column    = col[COL_W-1:0];
        r.cell_row       = row[ROW_W-1:0];
        r.region_columns = rcols[COL_W:0];
        r.region_rows    = rrows[ROW_W:0];
        r.status         = status;
        op_cmds.push_back(r);
    endfunction

    function automatic void apply_cfg(input logic [1:0] index, input logic [8:0] value);
        if (index == CFG_COLUMNS) reg_cols = value;
        else if (index == CFG_ROWS) reg_rows = value[7:0];
        else if (index == CFG_TEXT_MODE) text_on = value[0];
    endfunction

    function automatic void predict_put(input logic [15:0] ch);
        int unsigned cols;
        int unsigned rows;
        cols = live_cols();
        rows = live_rows();
        if (ch == CH_CR) begin
            cur_col = 0;
            add_cmd(CMD_NONE, 0, 0, 0, 0, 0, ST_OK);
        end else if (ch == CH_BS) begin
            // backspace at column zero steps back to the end of the row above
            if (cur_col == 0 && cur_row > 0) begin
                cur_row--;
                cur_col = cols - 1;
                add_cmd(CMD_DRAW, CH_SPACE, cur_col, cur_row, 0, 0, ST_OK);
            end else if (cur_col > 0) begin
                cur_col--;
                add_cmd(CMD_DRAW, CH_SPACE, cur_col, cur_row, 0, 0, ST_OK);
            end else begin
                add_cmd(CMD_NONE, 0, 0, 0, 0, 0, ST_OK);
            end
        end else if (ch == CH_LF) begin
            if (cur_row < rows - 1) begin
                cur_row++;
                if (cur_row > used_row) used_row = cur_row;
                add_cmd(CMD_NONE, 0, 0, 0, 0, 0, ST_OK);
            end else begin
                add_cmd(CMD_SCROLL, 0, 0, 0, used_col + 1, rows - 1, ST_OK);
            end
        end else begin
            add_cmd(CMD_DRAW, (ch == CH_TAB) ? CH_SPACE : ch, cur_col, cur_row, 0, 0, ST_OK);
            // the cursor is never re-clamped, so a shrunk screen wraps here
            if (cur_col < cols - 1) begin
                cur_col++;
                if (cur_col > used_col) used_col = cur_col;
            end else if (cur_row < rows - 1) begin
                cur_col = 0;
                cur_row++;
                if (cur_row > used_row) used_row = cur_row;
            end else begin
                add_cmd(CMD_SCROLL, 0, 0, 0, used_col + 1, rows - 1, ST_OK);
                cur_col = 0;
            end
        end
    endfunction

    function automatic void console_predict(input logic [2:0] op, input logic [15:0] ch,
                                            input logic [15:0] tc, input logic [15:0] tr,
                                            input logic [7:0] attr);
        int unsigned col_t;
        int unsigned row_t;
        logic [23:0] bg_new;
        op_cmds.delete();
        case (op)
            OP_PUT_CHAR: begin
                if (!text_on) add_cmd(CMD_NONE, 0, 0, 0, 0, 0, ST_UNSUPPORTED);
                else predict_put(ch);
            end
            OP_SET_CURSOR: begin
                col_t = tc;
                row_t = tr;
                if (col_t >= live_cols()) col_t = live_cols() - 1;
                if (row_t >= live_rows()) row_t = live_rows() - 1;
                cur_col = col_t;
                cur_row = row_t;
                if (col_t > used_col) used_col = col_t;
                if (row_t > used_row) used_row = row_t;
                add_cmd(CMD_NONE, 0, 0, 0, 0, 0, ST_OK);
            end
            OP_CLEAR: begin
                if (!text_on) begin
                    add_cmd(CMD_NONE, 0, 0, 0, 0, 0, ST_UNSUPPORTED);
                end else begin
                    if (uncontrolled) begin
                        add_cmd(CMD_FILL_ALL, 0, 0, 0, 0, 0, ST_OK);
                        uncontrolled = 1'b0;
                    end else begin
                        add_cmd(CMD_FILL_REGION, 0, 0, 0, used_col + 1, used_row + 1, ST_OK);
                    end
                    cur_col = 0;
                    cur_row = 0;
                    used_col = 0;
                    used_row = 0;
                end
            end
            OP_SET_ATTR: begin
                if (attr[7]) begin
                    add_cmd(CMD_NONE, 0, 0, 0, 0, 0, ST_UNSUPPORTED);
                end else begin
                    if (attr[6:0] != attr_now) begin
                        bg_new = palette_rgb({1'b0, attr[6:4]});
                        if (bg_new != bg_now) uncontrolled = 1'b1;
                        fg_now   = palette_rgb(attr[3:0]);
                        bg_now   = bg_new;
                        attr_now = attr[6:0];
                    end
                    add_cmd(CMD_NONE, 0, 0, 0, 0, 0, ST_OK);
                end
            end
            OP_MARK: begin
                uncontrolled = 1'b1;
                add_cmd(CMD_NONE, 0, 0, 0, 0, 0, ST_OK);
            end
            default: begin
                add_cmd(CMD_NONE, 0, 0, 0, 0, 0, ST_UNSUPPORTED);
            end
        endcase
        // every command carries the colours left after the operation
        foreach (op_cmds[k]) begin
            op_cmds[k].fg_rgb = fg_now;
            op_cmds[k].bg_rgb = bg_now;
            op_cmds[k].last   = (k == op_cmds.size() - 1);
            expected_cmds.push_back(op_cmds[k]);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    function automatic void check_cmd();
        t_result want;
        if (expected_cmds.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("command 0x%0h arrived with no request pending", cmd_code);
            return;
        end
        want = expected_cmds.pop_front();
        cmds_checked++;
        if (want.command == CMD_DRAW) draws_seen++;
        if (want.command == CMD_SCROLL) scrolls_seen++;
        if (want.command == CMD_FILL_REGION || want.command == CMD_FILL_ALL) fills_seen++;
        check_field("command", want.command, cmd_code);
        check_field("glyph_code", want.glyph_code, cmd_glyph);
        check_field("cell_column", want.cell_column, cmd_col);
        check_field("cell_row", want.cell_row, cmd_row);
        check_field("region_columns", want.region_columns, cmd_rcols);
        check_field("region_rows", want.region_rows, cmd_rrows);
        check_field("fg_rgb", want.fg_rgb, cmd_fg);
        check_field("bg_rgb", want.bg_rgb, cmd_bg);
        check_field("status", want.status, cmd_status);
        check_field("last", want.last, cmd_last);
    endfunction

    // both handshakes and register writes are seen here, before the edge updates
    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (cfg_we) apply_cfg(cfg_index, cfg_data);
            if (out_valid && !out_stall) begin
                quiet_cycles = 0;
                check_cmd();
            end
            if (in_valid && !in_stall) begin
                quiet_cycles = 0;
                reqs_sent++;
                console_predict(req_op, req_char, req_col, req_row, req_attr);
            end
            if (in_valid && in_stall) held_cycles++;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $error("no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_op(input logic [2:0] op, input logic [15:0] ch, input logic [15:0] tc,
                           input logic [15:0] tr, input logic [7:0] attr);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        req_op   <= op;
        req_char <= ch;
        req_col  <= tc;
        req_row  <= tr;
        req_attr <= attr;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic put_char(input logic [15:0] ch);
        send_op(OP_PUT_CHAR, ch, 16'h0, 16'h0, 8'h0);
    endtask

    task automatic send_random_op();
        logic [2:0]  op;
        logic [15:0] ch;
        logic [15:0] tc;
        logic [15:0] tr;
        logic [7:0]  attr;
        int unsigned pick;
        pick = $urandom_range(99);
        ch   = 16'($urandom);
        tc   = 16'($urandom);
        tr   = 16'($urandom);
        attr = 8'($urandom);
        if (pick < 55) begin
            op = OP_PUT_CHAR;
            // plenty of control characters, the rest printable or arbitrary
            case ($urandom_range(9))
                0: ch = CH_CR;
                1: ch = CH_BS;
                2, 3: ch = CH_LF;
                4: ch = CH_TAB;
                5, 6: ch = CH_SPACE + 16'($urandom_range(94));
                default: ;
            endcase
        end else if (pick < 70) begin
            op = OP_SET_CURSOR;
            if ($urandom_range(1) == 1) begin
                tc = 16'($urandom_range(15));
                tr = 16'($urandom_range(7));
            end
        end else if (pick < 78) begin
            op = OP_CLEAR;
        end else if (pick < 90) begin
            op = OP_SET_ATTR;
            if ($urandom_range(3) != 0) attr[7] = 1'b0;
        end else if (pick < 95) begin
            op = OP_MARK;
        end else begin
            op = 3'($urandom_range(7, 5));
        end
        send_op(op, ch, tc, tr, attr);
    endtask

    // stop offering and let every pending command come out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [8:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_geometry(input logic [8:0] cols, input logic [7:0] rows,
                                input logic mode);
        wait_idle();
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, {1'b0, rows});
        write_reg(CFG_TEXT_MODE, {8'h0, mode});
        geometry_count++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            IDLE_SEND: begin
                send_idle_pct  = 65;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct = 65;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 27;
                recv_stall_pct = 27;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // every operation and control character at the reset geometry
    task automatic test_directed_ops();
        set_idling(IDLE_NONE);
        put_char(CH_BS);
        put_char(16'h0041);
        put_char(16'hffff);
        put_char(16'h0000);
        put_char(CH_TAB);
        put_char(CH_CR);
        put_char(CH_LF);
        send_op(OP_SET_CURSOR, 16'h0, 16'hffff, 16'hffff, 8'h0);
        put_char(16'h005a);
        put_char(CH_LF);
        send_op(OP_SET_CURSOR, 16'h0, 16'h0, 16'h5, 8'h0);
        put_char(CH_BS);
        put_char(CH_BS);
        send_op(OP_SET_ATTR, 16'h0, 16'h0, 16'h0, 8'h80);
        send_op(OP_SET_ATTR, 16'h0, 16'h0, 16'h0, 8'hff);
        send_op(OP_SET_ATTR, 16'h0, 16'h0, 16'h0, 8'h07);
        send_op(OP_SET_ATTR, 16'h0, 16'h0, 16'h0, 8'h1f);
        send_op(OP_CLEAR, 16'h0, 16'h0, 16'h0, 8'h0);
        send_op(OP_CLEAR, 16'h0, 16'h0, 16'h0, 8'h0);
        send_op(OP_SET_ATTR, 16'h0, 16'h0, 16'h0, 8'h7f);
        send_op(OP_MARK, 16'h0, 16'h0, 16'h0, 8'h0);
        send_op(3'd5, 16'h0, 16'h0, 16'h0, 8'h0);
        send_op(3'd6, 16'h0, 16'h0, 16'h0, 8'h0);
        send_op(3'd7, 16'hffff, 16'hffff, 16'hffff, 8'hff);
        send_op(OP_CLEAR, 16'h0, 16'h0, 16'h0, 8'h0);
    endtask

    // graphics mode rejects put and clear, other operations still act
    task automatic test_graphics_mode();
        set_geometry(9'd80, 8'd25, 1'b0);
        put_char(16'h0041);
        put_char(CH_LF);
        send_op(OP_CLEAR, 16'h0, 16'h0, 16'h0, 8'h0);
        send_op(OP_SET_CURSOR, 16'h0, 16'd3, 16'd2, 8'h0);
        send_op(OP_SET_ATTR, 16'h0, 16'h0, 16'h0, 8'h20);
        set_geometry(9'd80, 8'd25, 1'b1);
        put_char(16'h0042);
    endtask

    // smallest, largest and out-of-range register values
    task automatic test_geometry_extremes();
        logic [8:0] col_set [4] = '{9'd0, 9'd1, 9'd256, 9'd511};
        logic [7:0] row_set [4] = '{8'd0, 8'd1, 8'd128, 8'd255};
        for (int g = 0; g < 4; g++) begin
            set_geometry(col_set[g], row_set[g], 1'b1);
            repeat (6) send_random_op();
            send_op(OP_SET_CURSOR, 16'h0, 16'hffff, 16'hffff, 8'h0);
            put_char(16'h0078);
            put_char(CH_LF);
            put_char(CH_BS);
            send_op(OP_SET_CURSOR, 16'h0, 16'h0, 16'h0, 8'h0);
            put_char(CH_BS);
            send_op(OP_CLEAR, 16'h0, 16'h0, 16'h0, 8'h0);
        end
    endtask

    // cursor left outside a screen that was made smaller
    task automatic test_shrunk_geometry();
        set_geometry(9'd256, 8'd128, 1'b1);
        send_op(OP_SET_CURSOR, 16'h0, 16'd200, 16'd100, 8'h0);
        put_char(16'h0041);
        set_geometry(9'd10, 8'd5, 1'b1);
        put_char(16'h0042);
        put_char(CH_LF);
        put_char(CH_BS);
        put_char(CH_TAB);
        send_op(OP_SET_CURSOR, 16'h0, 16'd200, 16'd100, 8'h0);
        put_char(16'h0043);
        send_op(OP_CLEAR, 16'h0, 16'h0, 16'h0, 8'h0);
    endtask

    // output held off long enough that the block must stall its input
    task automatic test_backpressure();
        set_geometry(9'd4, 8'd2, 1'b1);
        set_idling(IDLE_NONE);
        hold_req = 1'b1;
        repeat (PRESSURE_REQS) send_random_op();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [8:0] cols;
        logic [7:0] rows;
        int unsigned sel;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // small screens make wrap and scroll frequent
            sel = $urandom_range(9);
            if (sel < 6) begin
                cols = 9'($urandom_range(12, 1));
                rows = 8'($urandom_range(6, 1));
            end else if (sel < 8) begin
                cols = 9'($urandom);
                rows = 8'($urandom);
            end else begin
                cols = ($urandom_range(1) == 1) ? 9'd256 : 9'd1;
                rows = ($urandom_range(1) == 1) ? 8'd128 : 8'd1;
            end
            set_geometry(cols, rows, ($urandom_range(9) != 0));
            set_idling(p % 4);
            repeat (PHASE_REQS) send_random_op();
        end
        set_idling(IDLE_NONE);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_ops();
        test_graphics_mode();
        test_geometry_extremes();
        test_shrunk_geometry();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests, %0d commands (%0d draws, %0d scrolls, %0d fills)",
                 reqs_sent, cmds_checked, draws_seen, scrolls_seen, fills_seen);
        $display("over %0d screen settings; input held by back-pressure for %0d cycles",
                 geometry_count, held_cycles);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
